@@ rtl/spd_pkg.sv @@
package spd_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int DEBOUNCE_MS     = 30;

  localparam int ALPHA_W   = 14;
  localparam int SCALE_W   = 16;
  localparam int HYST_W    = 31;
  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [ALPHA_W-1:0] ALPHA_MIN = ALPHA_W'(1);
  localparam logic [ALPHA_W-1:0] ALPHA_MAX = ALPHA_W'(13107);

  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_THR  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_REL_HYST   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_SCL  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ALPHA = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT     = CFG_IDX_W'(4);

  localparam logic [DATA_W-1:0]  PRESS_THR_RST = DATA_W'(1000);
  localparam logic [HYST_W-1:0]  REL_HYST_RST  = HYST_W'(200);
  localparam logic [SCALE_W-1:0] FORCE_SCL_RST = SCALE_W'(256);
  localparam logic [ALPHA_W-1:0] ALPHA_RST     = ALPHA_W'(66);

  typedef struct packed {
    logic [DATA_W-1:0]  press_thr;
    logic [DATA_W-1:0]  rel_thr;
    logic [SCALE_W-1:0] scale;
    logic [ALPHA_W-1:0] alpha;
    logic               invert;
  } spd_cfg_t;

  typedef struct packed {
    logic accept;
    logic diff_en;
    logic diff_neg;
    logic bmul_en;
    logic badd_en;
    logic pmul_en;
    logic eval_en;
    logic zero_en;
  } spd_cmd_t;

  typedef struct packed {
    logic seeded;
    logic is_pressed;
  } spd_sts_t;

endpackage

@@ rtl/spd_cfg.sv @@
module spd_cfg import spd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  output spd_cfg_t             cfg_o
);

  logic [DATA_W-1:0]  thr_q, thr_d;
  logic [HYST_W-1:0]  hyst_q, hyst_d;
  logic [SCALE_W-1:0] scale_q, scale_d;
  logic [ALPHA_W-1:0] alpha_q, alpha_d;
  logic               inv_q, inv_d;
  logic [DATA_W-1:0]  rel_q, rel_d;
  logic [ALPHA_W-1:0] alpha_raw;
  logic [DATA_W-1:0]  hyst_x;

  assign cfg_ready_o = 1'b1;
  assign alpha_raw   = cfg_data_i[ALPHA_W-1:0];
  assign hyst_x      = {1'b0, hyst_q};

  always_comb begin
    thr_d   = thr_q;
    hyst_d  = hyst_q;
    scale_d = scale_q;
    alpha_d = alpha_q;
    inv_d   = inv_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PRESS_THR:  thr_d   = cfg_data_i;
        CFG_REL_HYST:   hyst_d  = cfg_data_i[HYST_W-1:0];
        CFG_FORCE_SCL:  scale_d = cfg_data_i[SCALE_W-1:0];
        CFG_BASE_ALPHA: begin
          priority if (alpha_raw < ALPHA_MIN) begin
            alpha_d = ALPHA_MIN;
          end else if (alpha_raw > ALPHA_MAX) begin
            alpha_d = ALPHA_MAX;
          end else begin
            alpha_d = alpha_raw;
          end
        end
        CFG_INVERT:     inv_d   = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // clamp hysteresis to the press level
  always_comb begin
    if ($signed(hyst_x) > $signed(thr_q)) begin
      rel_d = '0;
    end else begin
      rel_d = thr_q - hyst_x;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= PRESS_THR_RST;
      hyst_q  <= REL_HYST_RST;
      scale_q <= FORCE_SCL_RST;
      alpha_q <= ALPHA_RST;
      inv_q   <= 1'b0;
      rel_q   <= PRESS_THR_RST - DATA_W'(REL_HYST_RST);
    end else begin
      thr_q   <= thr_d;
      hyst_q  <= hyst_d;
      scale_q <= scale_d;
      alpha_q <= alpha_d;
      inv_q   <= inv_d;
      rel_q   <= rel_d;
    end
  end

  assign cfg_o.press_thr = thr_q;
  assign cfg_o.rel_thr   = rel_q;
  assign cfg_o.scale     = scale_q;
  assign cfg_o.alpha     = alpha_q;
  assign cfg_o.invert    = inv_q;

endmodule

@@ rtl/spd_ctrl.sv @@
module spd_ctrl import spd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  logic     action_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  spd_sts_t sts_i,
  output spd_cmd_t cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DIFF  = 8'b0000_0010,
    S_BMUL  = 8'b0000_0100,
    S_BADD  = 8'b0000_1000,
    S_DIFF2 = 8'b0001_0000,
    S_PMUL  = 8'b0010_0000,
    S_EVAL  = 8'b0100_0000,
    S_ZOUT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          priority if (action_i || !sts_i.seeded) begin
            state_d = S_ZOUT;
          end else if (sts_i.is_pressed) begin
            state_d = S_DIFF2;
          end else begin
            state_d = S_DIFF;
          end
        end
      end
      S_DIFF: begin
        cmd_o.diff_en = 1'b1;
        state_d       = S_BMUL;
      end
      S_BMUL: begin
        cmd_o.bmul_en = 1'b1;
        state_d       = S_BADD;
      end
      S_BADD: begin
        cmd_o.badd_en = 1'b1;
        state_d       = S_DIFF2;
      end
      S_DIFF2: begin
        cmd_o.diff_en  = 1'b1;
        cmd_o.diff_neg = 1'b1;
        state_d        = S_PMUL;
      end
      S_PMUL: begin
        cmd_o.pmul_en = 1'b1;
        state_d       = S_EVAL;
      end
      S_EVAL: begin
        if (out_free) begin
          cmd_o.eval_en = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_ZOUT: begin
        if (out_free) begin
          cmd_o.zero_en = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd_o.eval_en || cmd_o.zero_en) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/spd_dp.sv @@
module spd_dp import spd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  spd_cmd_t               cmd_i,
  input  spd_cfg_t               cfg_i,
  input  logic                   action_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic [DATA_W-1:0]      now_ms_i,
  output spd_sts_t               sts_o,
  output logic                   force_valid_o,
  output logic [DATA_W-1:0]      force_res_o,
  output logic                   changed_o,
  output logic                   pressed_o,
  output logic                   trigger_click_o
);

  localparam int FW = SAMPLE_BITS + 8;
  localparam int BW = SAMPLE_BITS + 16;
  localparam int DW = BW + 1;
  localparam int MW = DW + ALPHA_W + 1;
  localparam int PW = DW + SCALE_W;
  localparam int HW = PW - 24;
  localparam int SW = (HW > DATA_W + 1) ? HW : DATA_W + 1;

  localparam logic signed [SW-1:0] RES_MAX = SW'($signed(32'h7fff_ffff));
  localparam logic signed [SW-1:0] RES_MIN = SW'($signed(32'h8000_0000));

  logic                 seeded_q;
  logic                 pressed_q;
  logic [FW-1:0]        f_q;
  logic [BW-1:0]        b_q;
  logic [DATA_W-1:0]    last_q;
  logic [DATA_W-1:0]    now_q;
  logic signed [DW-1:0] d_q;
  logic signed [MW-1:0] prod_q;
  logic signed [PW-1:0] p_q;

  logic                 fv_q, chg_q, prs_q, clk_q;
  logic [DATA_W-1:0]    res_q;

  logic [FW-1:0]        s_f;
  logic [BW-1:0]        f_sh;
  logic signed [FW:0]   f_diff;
  logic signed [FW:0]   f_step;
  logic signed [DW-1:0] d_l, d_r, d_next;
  logic signed [SW-1:0] sh_x, thr_x, rel_x;
  logic [DATA_W-1:0]    sat;
  logic                 press_hit, rel_hit, gap_ok;

  assign s_f    = {sample_i, 8'b0};
  assign f_sh   = {f_q, 8'b0};
  assign f_diff = $signed({s_f[FW-1], s_f}) - $signed({f_q[FW-1], f_q});
  assign f_step = f_diff >>> 2;

  assign d_l    = $signed({f_sh[BW-1], f_sh});
  assign d_r    = $signed({b_q[BW-1], b_q});
  assign d_next = cmd_i.diff_neg && cfg_i.invert ? d_r - d_l : d_l - d_r;

  assign sh_x  = SW'($signed(p_q[PW-1:24]));
  assign thr_x = SW'($signed(cfg_i.press_thr));
  assign rel_x = SW'($signed(cfg_i.rel_thr));

  always_comb begin
    priority if (sh_x > RES_MAX) begin
      sat = RES_MAX[DATA_W-1:0];
    end else if (sh_x < RES_MIN) begin
      sat = RES_MIN[DATA_W-1:0];
    end else begin
      sat = sh_x[DATA_W-1:0];
    end
  end

  assign press_hit = (sh_x >= thr_x);
  assign rel_hit   = (sh_x < rel_x) || ((sh_x == rel_x) && (p_q[23:0] == '0));
  assign gap_ok    = ((now_q - last_q) >= DATA_W'(DEBOUNCE_MS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seeded_q  <= 1'b0;
      pressed_q <= 1'b0;
      f_q       <= '0;
      b_q       <= '0;
      last_q    <= '0;
    end else begin
      if (cmd_i.accept) begin
        priority if (action_i) begin
          b_q <= f_sh;
        end else if (!seeded_q) begin
          f_q      <= s_f;
          b_q      <= {sample_i, 16'b0};
          seeded_q <= 1'b1;
        end else begin
          f_q <= f_q + f_step[FW-1:0];
        end
      end
      if (cmd_i.badd_en) begin
        b_q <= b_q + prod_q[MW-1:16];
      end
      if (cmd_i.eval_en && gap_ok) begin
        priority if (!pressed_q && press_hit) begin
          pressed_q <= 1'b1;
          last_q    <= now_q;
        end else if (pressed_q && rel_hit) begin
          pressed_q <= 1'b0;
          last_q    <= now_q;
        end else begin
          pressed_q <= pressed_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      now_q <= now_ms_i;
    end
    if (cmd_i.diff_en) begin
      d_q <= d_next;
    end
    if (cmd_i.bmul_en) begin
      prod_q <= d_q * $signed({1'b0, cfg_i.alpha});
    end
    if (cmd_i.pmul_en) begin
      p_q <= d_q * $signed(cfg_i.scale);
    end
    if (cmd_i.zero_en) begin
      fv_q  <= 1'b0;
      res_q <= '0;
      chg_q <= 1'b0;
      prs_q <= 1'b0;
      clk_q <= 1'b0;
    end else if (cmd_i.eval_en) begin
      fv_q  <= 1'b1;
      res_q <= sat;
      priority if (!pressed_q && press_hit && gap_ok) begin
        chg_q <= 1'b1;
        prs_q <= 1'b1;
        clk_q <= 1'b1;
      end else if (pressed_q && rel_hit && gap_ok) begin
        chg_q <= 1'b1;
        prs_q <= 1'b0;
        clk_q <= 1'b0;
      end else begin
        chg_q <= 1'b0;
        prs_q <= 1'b0;
        clk_q <= 1'b0;
      end
    end
  end

  assign sts_o.seeded     = seeded_q;
  assign sts_o.is_pressed = pressed_q;

  assign force_valid_o   = fv_q;
  assign force_res_o     = res_q;
  assign changed_o       = chg_q;
  assign pressed_o       = prs_q;
  assign trigger_click_o = clk_q;

endmodule

@@ rtl/strain_press_detector.sv @@
// Press/release detector for a load-cell pad.
// Input channel: one word per converter sample or calibrate action, taken
// when in_valid_i is high and in_stall_o is low. Output channel: one result
// word per input word, taken when out_valid_o is high and out_stall_i is low.
// Configuration: cfg_index_i selects press threshold, release hysteresis,
// force scale, baseline alpha or sign inversion; cfg_ready_o is always high.
// Steps from input accept to loading the output register:
//   calibrate or seeding sample: zero result word only
//   sample while pressed: difference, force multiply, evaluate
//   sample while released: baseline difference, multiply, update, then as pressed
// One word is worked on at a time; the controller walks the shared
// difference register and the multiply steps, taking no new word until the
// last one has loaded the output register, which holds a finished word
// while the receiver stalls; the last step waits until that register frees.
// Reset clears the filter, baseline, pressed state and edge time, and loads
// the register defaults; the first sample after reset seeds the filter.
module strain_press_detector import spd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   action_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic [DATA_W-1:0]      now_ms_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   force_valid_o,
  output logic [DATA_W-1:0]      force_res_o,
  output logic                   changed_o,
  output logic                   pressed_o,
  output logic                   trigger_click_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [DATA_W-1:0]      cfg_data_i
);

  spd_cfg_t cfg;
  spd_cmd_t cmd;
  spd_sts_t sts;

  spd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  spd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  spd_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_i           (cfg),
    .action_i        (action_i),
    .sample_i        (sample_i),
    .now_ms_i        (now_ms_i),
    .sts_o           (sts),
    .force_valid_o   (force_valid_o),
    .force_res_o     (force_res_o),
    .changed_o       (changed_o),
    .pressed_o       (pressed_o),
    .trigger_click_o (trigger_click_o)
  );

endmodule

@@ rtl/spd_chk.sv @@
module spd_chk import spd_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic              force_valid_o,
  input logic [DATA_W-1:0] force_res_o,
  input logic              changed_o,
  input logic              pressed_o,
  input logic              trigger_click_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(force_res_o) && $stable(changed_o))
    else $error("stalled result word changed");

  a_click_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && trigger_click_o |-> changed_o && pressed_o)
    else $error("press click without press edge");

  a_pressed_click: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pressed_o |-> trigger_click_o)
    else $error("pressed flag outside a press edge");

  a_edge_force: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && changed_o |-> force_valid_o)
    else $error("edge reported without a force value");

  a_zero_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !force_valid_o |-> force_res_o == '0)
    else $error("force value on a word without force");

endmodule

bind strain_press_detector spd_chk u_spd_chk (.*);

@@ test/strain_press_detector_test.sv @@
`timescale 1ns / 1ps

module strain_press_detector_test;
  import spd_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int IDLE_MAX     = 18;
  localparam int HOLD_CYCLES  = 300;
  localparam int STUCK_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 12;
  localparam int REPORT_MAX   = 10;
  localparam int SAMPLE_SPAN  = 1 << (SAMPLE_BITS_DEF - 1);
  localparam longint FORCE_ONE = 64'sd16777216;
  localparam longint FORCE_MAX = 64'sd2147483647;
  localparam longint FORCE_MIN = -64'sd2147483648;

  typedef enum logic {
    ACT_SAMPLE    = 1'b0,
    ACT_CALIBRATE = 1'b1
  } press_action_e;

  typedef struct packed {
    press_action_e              action;
    logic [SAMPLE_BITS_DEF-1:0] sample;
    logic [DATA_W-1:0]          now_ms;
  } press_word_t;

  typedef struct packed {
    logic              force_valid;
    logic [DATA_W-1:0] force_res;
    logic              changed;
    logic              pressed;
    logic              trigger_click;
  } press_result_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic                       action_i = 1'b0;
  logic [SAMPLE_BITS_DEF-1:0] sample_i = '0;
  logic [DATA_W-1:0]          now_ms_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic                       force_valid_o;
  logic [DATA_W-1:0]          force_res_o;
  logic                       changed_o;
  logic                       pressed_o;
  logic                       trigger_click_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i = '0;
  logic [DATA_W-1:0]          cfg_data_i = '0;

  strain_press_detector dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .sample_i       (sample_i),
    .now_ms_i       (now_ms_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .force_valid_o  (force_valid_o),
    .force_res_o    (force_res_o),
    .changed_o      (changed_o),
    .pressed_o      (pressed_o),
    .trigger_click_o(trigger_click_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // detector state and register copies
  longint            thr_m    = longint'($signed(PRESS_THR_RST));
  longint            hyst_m   = longint'(REL_HYST_RST);
  longint            scale_m  = longint'($signed(FORCE_SCL_RST));
  longint            alpha_m  = longint'(ALPHA_RST);
  bit                invert_m = 1'b0;
  bit                seeded_m = 1'b0;
  longint            filt_m   = 0;
  longint            base_m   = 0;
  bit                pressed_m = 1'b0;
  logic [DATA_W-1:0] last_edge_m = '0;

  press_word_t   pending_words[$];
  press_result_t expected_results[$];
  press_word_t   cur_word;

  int idle_odds = 0;
  bit hold_armed = 1'b0;
  bit hold_done = 1'b0;
  int hold_cycles = 0;
  logic long_hold = 1'b0;
  int send_gap = 0;
  int stall_left = 0;

  int mismatches = 0;
  int words_taken = 0;
  int results_checked = 0;
  int calibrations = 0;
  int press_edges = 0;
  int release_edges = 0;
  int saturations = 0;
  int settings_loaded = 0;

  function automatic press_result_t predict_press_result(press_word_t w);
    press_result_t     r;
    longint            s;
    longint            p;
    longint            fr;
    longint            rel;
    logic [DATA_W-1:0] since_edge;
    bit                gap_ok;
    r = '0;
    if (w.action == ACT_CALIBRATE) begin
      base_m = filt_m * 256;
      calibrations++;
      return r;
    end
    s = longint'($signed(w.sample));
    if (!seeded_m) begin
      filt_m = s * 256;
      base_m = s * 65536;
      seeded_m = 1'b1;
      return r;
    end
    filt_m += (s * 256 - filt_m) >>> 2;
    if (!pressed_m) begin
      base_m += ((filt_m * 256 - base_m) * alpha_m) >>> 16;
    end
    p = (filt_m * 256 - base_m) * scale_m;
    if (invert_m) begin
      p = -p;
    end
    fr = p >>> 24;
    if (fr > FORCE_MAX) begin
      fr = FORCE_MAX;
      saturations++;
    end else if (fr < FORCE_MIN) begin
      fr = FORCE_MIN;
      saturations++;
    end
    r.force_valid = 1'b1;
    r.force_res = fr[DATA_W-1:0];
    rel = thr_m - ((hyst_m > thr_m) ? thr_m : hyst_m);
    since_edge = w.now_ms - last_edge_m;
    gap_ok = since_edge >= DEBOUNCE_MS;
    if (!pressed_m && p >= thr_m * FORCE_ONE && gap_ok) begin
      pressed_m = 1'b1;
      last_edge_m = w.now_ms;
      r.changed = 1'b1;
      r.pressed = 1'b1;
      r.trigger_click = 1'b1;
      press_edges++;
    end else if (pressed_m && p <= rel * FORCE_ONE && gap_ok) begin
      pressed_m = 1'b0;
      last_edge_m = w.now_ms;
      r.changed = 1'b1;
      release_edges++;
    end
    return r;
  endfunction

  function automatic logic [SAMPLE_BITS_DEF-1:0] clip_sample(longint v);
    if (v > SAMPLE_SPAN - 1) begin
      return SAMPLE_BITS_DEF'(SAMPLE_SPAN - 1);
    end
    if (v < -SAMPLE_SPAN) begin
      return SAMPLE_BITS_DEF'(-SAMPLE_SPAN);
    end
    return v[SAMPLE_BITS_DEF-1:0];
  endfunction

  function automatic void push_word(press_action_e a, logic [SAMPLE_BITS_DEF-1:0] s,
                                    logic [DATA_W-1:0] t);
    press_word_t w;
    w.action = a;
    w.sample = s;
    w.now_ms = t;
    pending_words.push_back(w);
  endfunction

  // rest at a level, step by a random amount, return; mixes in calibrations
  function automatic void queue_press_sequences(int count);
    int                made;
    int                seg;
    int                len;
    int                k;
    int                level;
    int                amp;
    int                noise;
    longint            v;
    logic [DATA_W-1:0] t;
    made = 0;
    while (made < count) begin
      level = int'($urandom_range(0, (1 << SAMPLE_BITS_DEF) - 1)) - SAMPLE_SPAN;
      amp = int'($urandom_range(0, (1 << $urandom_range(3, SAMPLE_BITS_DEF)) - 1));
      if ($urandom_range(0, 1) == 1) begin
        amp = -amp;
      end
      noise = int'($urandom_range(0, 40));
      t = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 800) : $urandom;
      for (seg = 0; seg < 3; seg++) begin
        len = int'($urandom_range(2, 10));
        for (k = 0; k < len; k++) begin
          t += ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5) : $urandom_range(5, 40);
          case ($urandom_range(0, 24))
            0, 1: push_word(ACT_CALIBRATE, SAMPLE_BITS_DEF'($urandom), t);
            2: push_word(ACT_SAMPLE, SAMPLE_BITS_DEF'($urandom), t);
            default: begin
              v = longint'(level) + ((seg == 1) ? amp : 0)
                  + int'($urandom_range(0, 2 * noise)) - noise;
              push_word(ACT_SAMPLE, clip_sample(v), t);
            end
          endcase
          made++;
        end
      end
    end
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    logic [ALPHA_W-1:0] a;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    a = data[ALPHA_W-1:0];
    case (idx)
      CFG_PRESS_THR:  thr_m = longint'($signed(data));
      CFG_REL_HYST:   hyst_m = longint'(data[HYST_W-1:0]);
      CFG_FORCE_SCL:  scale_m = longint'($signed(data[SCALE_W-1:0]));
      CFG_BASE_ALPHA: alpha_m = longint'((a < ALPHA_MIN) ? ALPHA_MIN :
                                         (a > ALPHA_MAX) ? ALPHA_MAX : a);
      CFG_INVERT:     invert_m = data[0];
      default: ;
    endcase
  endtask

  task automatic load_settings(logic [DATA_W-1:0] thr, logic [DATA_W-1:0] hyst,
                               logic [DATA_W-1:0] scale, logic [DATA_W-1:0] alpha,
                               logic [DATA_W-1:0] inv, bit with_spare);
    int unsigned k;
    write_reg(CFG_PRESS_THR, thr);
    write_reg(CFG_REL_HYST, hyst);
    write_reg(CFG_FORCE_SCL, scale);
    write_reg(CFG_BASE_ALPHA, alpha);
    write_reg(CFG_INVERT, inv);
    if (with_spare) begin
      for (k = CFG_INVERT + 1; k < (1 << CFG_IDX_W); k++) begin
        write_reg(CFG_IDX_W'(k), $urandom);
      end
    end
    cfg_valid_i <= 1'b0;
    settings_loaded++;
  endtask

  task automatic drain_block();
    do @(negedge clk_i);
    while (pending_words.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(predict_press_result(cur_word));
        words_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_words.size() != 0) begin
          cur_word = pending_words.pop_front();
          action_i <= cur_word.action;
          sample_i <= cur_word.sample;
          now_ms_i <= cur_word.now_ms;
          in_valid_i <= 1'b1;
          if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            send_gap = int'($urandom_range(1, IDLE_MAX));
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    press_result_t got;
    press_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.force_valid = force_valid_o;
        got.force_res = force_res_o;
        got.changed = changed_o;
        got.pressed = pressed_o;
        got.trigger_click = trigger_click_o;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("%0t: result word with nothing pending: fv=%0b force=%0d chg=%0b prs=%0b clk=%0b",
                     $realtime, got.force_valid, $signed(got.force_res), got.changed,
                     got.pressed, got.trigger_click);
          end
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("%0t: word %0d expected fv=%0b force=%0d chg=%0b prs=%0b clk=%0b",
                       $realtime, results_checked, want.force_valid, $signed(want.force_res),
                       want.changed, want.pressed, want.trigger_click);
              $display("%0t: word %0d got      fv=%0b force=%0d chg=%0b prs=%0b clk=%0b",
                       $realtime, results_checked, got.force_valid, $signed(got.force_res),
                       got.changed, got.pressed, got.trigger_click);
            end
          end
        end
      end
      if (stall_left == 0 && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        stall_left = int'($urandom_range(1, IDLE_MAX));
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= long_hold;
      end
    end
  end

  // hold the output back long enough for the block to back up into its input
  always @(posedge clk_i) begin
    if (hold_armed && !hold_done) begin
      hold_cycles++;
      long_hold <= (hold_cycles < HOLD_CYCLES);
      if (hold_cycles >= HOLD_CYCLES) begin
        hold_done = 1'b1;
      end
    end
  end

  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("watchdog: no handshake for %0d cycles", STUCK_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int                ph;
    int                fails;
    logic [DATA_W-1:0] thr;
    logic [DATA_W-1:0] hyst;
    logic [DATA_W-1:0] scale;
    logic [DATA_W-1:0] alpha;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    idle_odds = 5;
    push_word(ACT_CALIBRATE, '0, 32'd0);
    push_word(ACT_SAMPLE, 24'd100, 32'd5);
    push_word(ACT_SAMPLE, 24'd100, 32'd10);
    push_word(ACT_SAMPLE, 24'd8100, 32'd20);
    push_word(ACT_SAMPLE, 24'd8100, 32'd40);
    push_word(ACT_SAMPLE, 24'd8100, 32'd45);
    push_word(ACT_SAMPLE, 24'h80_0000, 32'd55);
    push_word(ACT_SAMPLE, 24'h80_0000, 32'd80);
    push_word(ACT_SAMPLE, 24'h7F_FFFF, 32'd200);
    push_word(ACT_SAMPLE, 24'h7F_FFFF, 32'd210);
    push_word(ACT_CALIBRATE, '1, 32'd215);
    push_word(ACT_SAMPLE, 24'h7F_FFFF, 32'd250);
    push_word(ACT_SAMPLE, 24'h80_0000, 32'hFFFF_FFF0);
    push_word(ACT_SAMPLE, 24'h80_0000, 32'h0000_0008);
    push_word(ACT_SAMPLE, 24'h7F_FFFF, 32'hFFFF_FFFF);
    push_word(ACT_SAMPLE, 24'h7F_FFFF, 32'h0000_0020);
    push_word(ACT_SAMPLE, 24'h00_0000, 32'h0000_0060);
    push_word(ACT_SAMPLE, 24'hFF_FFFF, 32'h0000_0090);
    drain_block();

    load_settings(32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_8000, 32'h0, 32'h1, 1'b1);
    @(negedge clk_i);
    queue_press_sequences(30);
    drain_block();

    load_settings(32'h7FFF_FFFF, 32'h0, 32'h0000_7FFF, 32'hFFFF_FFFF, 32'h0, 1'b0);
    @(negedge clk_i);
    queue_press_sequences(30);
    drain_block();

    load_settings(32'h0, 32'h0, 32'h0000_0001, 32'h0000_4000, 32'h1, 1'b0);
    @(negedge clk_i);
    queue_press_sequences(30);
    drain_block();

    for (ph = 0; ph < 9; ph++) begin
      case ($urandom_range(0, 4))
        0: thr = $urandom_range(1, 3000);
        1: thr = $urandom_range(3000, 200000);
        2: thr = -$urandom_range(0, 5000);
        3: thr = $urandom;
        default: thr = $urandom_range(0, 500);
      endcase
      case ($urandom_range(0, 2))
        0: hyst = $urandom_range(0, 500);
        1: hyst = $urandom_range(0, 5000);
        default: hyst = $urandom;
      endcase
      case ($urandom_range(0, 2))
        0: scale = $urandom_range(16, 1024);
        1: scale = -$urandom_range(16, 1024);
        default: scale = $urandom;
      endcase
      case ($urandom_range(0, 2))
        0: alpha = $urandom_range(1, 300);
        1: alpha = $urandom_range(0, 16383);
        default: alpha = $urandom;
      endcase
      load_settings(thr, hyst, scale, alpha, $urandom, ph % 3 == 0);
      @(negedge clk_i);
      idle_odds = (ph == 3 || ph == 8) ? 0 : int'($urandom_range(2, 12));
      hold_armed = (ph == 3);
      queue_press_sequences((ph == 8) ? 150 : 200);
      drain_block();
    end

    fails = mismatches + expected_results.size();
    if (expected_results.size() != 0) begin
      $display("%0d expected result words never arrived", expected_results.size());
    end
    $display("ran %0d words (%0d calibrate) under %0d register settings, %0d results checked",
             words_taken, calibrations, settings_loaded, results_checked);
    $display("saw %0d press and %0d release edges, %0d saturated forces, %0d mismatches",
             press_edges, release_edges, saturations, mismatches);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ strain_press_detector.f @@
rtl/spd_pkg.sv
rtl/spd_cfg.sv
rtl/spd_ctrl.sv
rtl/spd_dp.sv
rtl/strain_press_detector.sv
rtl/spd_chk.sv
test/strain_press_detector_test.sv
